// ----- hw/rtl/hdlc_frame_encoder_crc16_macros.svh -----
// Assertion macros shared by the frame encoder modules.
`ifndef HDLC_FRAME_ENCODER_CRC16_MACROS_SVH
`define HDLC_FRAME_ENCODER_CRC16_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame encoder assertion failed");

`endif

// ----- hw/rtl/hfe_pkg.sv -----
`default_nettype none

package hfe_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_FLAG  = 8'h5E;
    localparam logic [7:0]  ESC_ESC   = 8'h5D;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;

    localparam int QUEUE_DEPTH = 4;

    // One classified payload byte, as handed from the front to the back.
    typedef struct packed {
        logic        open_flag;
        logic        escape;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] fcs;
    } job_t;

    // Bitwise CRC-16/X-25 update over one byte, least significant bit first.
    function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic needs_escape(logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [7:0] escaped_byte(logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hfe_channels.sv -----
`default_nettype none

interface hfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface hfe_cfg_if;
    logic valid;
    logic ready;
    logic opening_flag_enable;

    modport source (output valid, output opening_flag_enable, input ready);
    modport sink   (input valid, input opening_flag_enable, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hfe_front.sv -----
`default_nettype none
`include "hdlc_frame_encoder_crc16_macros.svh"

module hfe_front (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hfe_in_if.sink       frame_in,
    hfe_cfg_if.sink      cfg,
    output hfe_pkg::job_t push_job,
    output logic         push_valid,
    input  wire logic    push_ready
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        first_reg;
    logic        first_next;
    logic        flag_en_reg;
    logic        accept;
    logic [15:0] crc_upd;

    assign frame_in.ready = push_ready;
    assign cfg.ready      = 1'b1;
    assign accept         = frame_in.valid && push_ready;
    assign push_valid     = accept;

    assign crc_upd = hfe_pkg::crc_update(crc_reg, frame_in.data_byte);

    always_comb
    begin
        crc_next   = crc_reg;
        first_next = first_reg;
        if (accept)
        begin
            crc_next   = frame_in.last_byte ? hfe_pkg::CRC_INIT : crc_upd;
            first_next = frame_in.last_byte;
        end
    end

    always_comb
    begin
        push_job.open_flag = first_reg && flag_en_reg;
        push_job.escape    = !first_reg;
        push_job.data_byte = frame_in.data_byte;
        push_job.last_byte = frame_in.last_byte;
        push_job.fcs       = ~crc_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= hfe_pkg::CRC_INIT;
            first_reg   <= 1'b1;
            flag_en_reg <= 1'b1;
        end
        else
        begin
            crc_reg   <= crc_next;
            first_reg <= first_next;
            if (cfg.valid)
            begin
                flag_en_reg <= cfg.opening_flag_enable;
            end
        end
    end

    // The end of a frame must leave the checksum ready for the next one.
    `HFE_ASSERT_NEXT(a_frame_restart, clk, rst_n, accept && frame_in.last_byte, crc_reg == hfe_pkg::CRC_INIT && first_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/hfe_queue.sv -----
`default_nettype none
`include "hdlc_frame_encoder_crc16_macros.svh"

module hfe_queue #(
    parameter int DEPTH = hfe_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire hfe_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output hfe_pkg::job_t      pop_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hfe_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `HFE_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))

endmodule

`default_nettype wire

// ----- hw/rtl/hfe_back.sv -----
`default_nettype none
`include "hdlc_frame_encoder_crc16_macros.svh"

module hfe_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire hfe_pkg::job_t job,
    output logic               job_pop,
    hfe_out_if.source          frame_out
);

    typedef enum logic [3:0] {
        PH_START,
        PH_FLAG,
        PH_DATA,
        PH_DATA_ESC,
        PH_FCS_LO,
        PH_FCS_LO_ESC,
        PH_FCS_HI,
        PH_FCS_HI_ESC,
        PH_CLOSE
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     phase_eff;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       load;
    logic       out_is_last;
    logic       close_load;

    assign frame_out.valid    = out_valid_reg;
    assign frame_out.out_byte = out_byte_reg;
    assign frame_out.out_last = out_last_reg;

    // The output register takes a new byte whenever it is empty or being drained.
    assign load = !out_valid_reg || frame_out.ready;

    assign out_is_last = out_valid_reg && out_last_reg;
    assign close_load  = load && job_valid && (phase_eff == PH_CLOSE);

    always_comb
    begin
        if (phase_reg == PH_START)
        begin
            phase_eff = job.open_flag ? PH_FLAG : PH_DATA;
        end
        else
        begin
            phase_eff = phase_reg;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        job_pop        = 1'b0;
        if (load)
        begin
            out_valid_next = job_valid;
            if (job_valid)
            begin
                out_last_next = 1'b0;
                unique case (phase_eff) inside
                    PH_FLAG:
                    begin
                        out_byte_next = hfe_pkg::FLAG_BYTE;
                        phase_next    = PH_DATA;
                    end
                    PH_DATA, PH_DATA_ESC:
                    begin
                        if (phase_eff == PH_DATA && job.escape
                            && hfe_pkg::needs_escape(job.data_byte))
                        begin
                            out_byte_next = hfe_pkg::ESC_BYTE;
                            phase_next    = PH_DATA_ESC;
                        end
                        else
                        begin
                            out_byte_next = (phase_eff == PH_DATA_ESC)
                                ? hfe_pkg::escaped_byte(job.data_byte) : job.data_byte;
                            if (job.last_byte)
                            begin
                                phase_next = PH_FCS_LO;
                            end
                            else
                            begin
                                phase_next = PH_START;
                                job_pop    = 1'b1;
                            end
                        end
                    end
                    PH_FCS_LO:
                    begin
                        if (hfe_pkg::needs_escape(job.fcs[7:0]))
                        begin
                            out_byte_next = hfe_pkg::ESC_BYTE;
                            phase_next    = PH_FCS_LO_ESC;
                        end
                        else
                        begin
                            out_byte_next = job.fcs[7:0];
                            phase_next    = PH_FCS_HI;
                        end
                    end
                    PH_FCS_LO_ESC:
                    begin
                        out_byte_next = hfe_pkg::escaped_byte(job.fcs[7:0]);
                        phase_next    = PH_FCS_HI;
                    end
                    PH_FCS_HI:
                    begin
                        if (hfe_pkg::needs_escape(job.fcs[15:8]))
                        begin
                            out_byte_next = hfe_pkg::ESC_BYTE;
                            phase_next    = PH_FCS_HI_ESC;
                        end
                        else
                        begin
                            out_byte_next = job.fcs[15:8];
                            phase_next    = PH_CLOSE;
                        end
                    end
                    PH_FCS_HI_ESC:
                    begin
                        out_byte_next = hfe_pkg::escaped_byte(job.fcs[15:8]);
                        phase_next    = PH_CLOSE;
                    end
                    PH_CLOSE:
                    begin
                        out_byte_next = hfe_pkg::FLAG_BYTE;
                        out_last_next = 1'b1;
                        phase_next    = PH_START;
                        job_pop       = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    // A job stays at the head of the queue until its last output byte is produced.
    `HFE_ASSERT_SAME(a_job_held, clk, rst_n, phase_reg != PH_START, job_valid)
    `HFE_ASSERT_SAME(a_last_is_flag, clk, rst_n, out_is_last, out_byte_reg == hfe_pkg::FLAG_BYTE)
    `HFE_ASSERT_NEXT(a_close_resets, clk, rst_n, close_load, phase_reg == PH_START)

endmodule

`default_nettype wire

// ----- hw/rtl/hdlc_frame_encoder_crc16.sv -----
// Channel    Direction  Payload                        Transfer when
// frame_in   in         data_byte[7:0], last_byte      valid && ready
// frame_out  out        out_byte[7:0], out_last        valid && ready
// cfg        in         opening_flag_enable            valid && ready (ready is always high)
//
// Each input byte becomes one to seven output bytes, one output byte per cycle while the
// output is ready; an escaped byte is sent as the escape byte and then its escaped form.
// The back-end byte sequencer sets the rate; the front accepts while the job queue has room.
// Reset puts the checksum at 0xFFFF, marks the next byte as a frame start and sets the
// opening flag enable; the queue and output register come up empty.
// A stall on frame_out fills the job queue before frame_in ready drops.
`default_nettype none

module hdlc_frame_encoder_crc16 #(
    parameter int QUEUE_DEPTH = hfe_pkg::QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hfe_in_if.sink    frame_in,
    hfe_out_if.source frame_out,
    hfe_cfg_if.sink   cfg
);

    hfe_pkg::job_t push_job;
    hfe_pkg::job_t head_job;
    logic          push_valid;
    logic          push_ready;
    logic          head_valid;
    logic          head_pop;

    hfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .cfg        (cfg),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    hfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_job    (head_job)
    );

    hfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (head_pop),
        .frame_out (frame_out)
    );

endmodule

`default_nettype wire
